FILE: hdl/dro_pkg.sv
// ----------------------------------------------------------------------------
// Dead-reckoning odometry package
// Shared types, fixed-point constants and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
package dro_pkg;

    // Sequencer states of the top level.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TRIG,
        ST_SCALE,
        ST_DIVIDE,
        ST_EMIT
    } t_state;

    // One command transfer.
    typedef struct packed {
        logic signed [15:0] linear_velocity;
        logic signed [15:0] angular_velocity;
        logic        [15:0] elapsed_time;
    } t_cmd_item;

    // One pose transfer.
    typedef struct packed {
        logic signed [31:0] position_x;
        logic signed [31:0] position_y;
        logic        [15:0] heading;
        logic signed [15:0] quat_z;
        logic signed [15:0] quat_w;
    } t_pose_item;

    // CORDIC datapath: 32-bit full-turn angle, x and y scaled by 2^30.
    localparam int ANGLE_W   = 32;
    localparam int XY_W      = 33;
    localparam logic signed [XY_W-1:0] CORDIC_GAIN = 33'sd652032874;

    // Shift-add multiplier operands: a 31-bit magnitude times a 16-bit one.
    localparam int MUL_A_W = 31;
    localparam int MUL_B_W = 16;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;

    // Position step: round(|v*c|*dt / 512e6).
    localparam int POS_DIV_W  = 29;
    localparam int POS_QUOT_W = 18;
    localparam logic [POS_DIV_W-1:0] POS_DIVISOR = 29'd512000000;
    localparam logic [POS_DIV_W-1:0] POS_HALF    = 29'd256000000;

    // Heading step: round(|w|*dt*2^HW / (4096e6 * 2*pi)).
    localparam int TURN_DIV_W = 35;
    localparam logic [TURN_DIV_W-1:0] TURN_DIVISOR = 35'd25735927018;
    localparam logic [TURN_DIV_W-1:0] TURN_HALF    = 35'd12867963509;

    // atan(2^-i) as a fraction of a full turn, scaled by 2^32.
    function automatic logic [ANGLE_W-1:0] atan_turn(input logic [4:0] idx);
        logic [ANGLE_W-1:0] val;
        case (idx)
            5'd0:    val = 32'h20000000;
            5'd1:    val = 32'h12E4051E;
            5'd2:    val = 32'h09FB385B;
            5'd3:    val = 32'h051111D4;
            5'd4:    val = 32'h028B0D43;
            5'd5:    val = 32'h0145D7E1;
            5'd6:    val = 32'h00A2F61E;
            5'd7:    val = 32'h00517C55;
            5'd8:    val = 32'h0028BE53;
            5'd9:    val = 32'h00145F2F;
            5'd10:   val = 32'h000A2F98;
            5'd11:   val = 32'h000517CC;
            5'd12:   val = 32'h00028BE6;
            5'd13:   val = 32'h000145F3;
            5'd14:   val = 32'h0000A2F9;
            5'd15:   val = 32'h0000517D;
            5'd16:   val = 32'h000028BE;
            5'd17:   val = 32'h0000145F;
            5'd18:   val = 32'h00000A30;
            5'd19:   val = 32'h00000518;
            5'd20:   val = 32'h0000028C;
            5'd21:   val = 32'h00000146;
            5'd22:   val = 32'h000000A3;
            5'd23:   val = 32'h00000051;
            default: val = '0;
        endcase
        return val;
    endfunction

endpackage

FILE: hdl/dro_stream_if.sv
// ----------------------------------------------------------------------------
// Stream channel
// Valid/ready channel carrying one payload of type T per transfer.
// ----------------------------------------------------------------------------
interface dro_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: hdl/dead_reckoning_odometry_top.sv
// ----------------------------------------------------------------------------
// Dead-reckoning odometry
// Unicycle-model pose integrator: each command advances x and y along the old
// heading, then the heading, and reports the pose with its yaw quaternion.
// ----------------------------------------------------------------------------
// Usage:
// A command transfer on i_cmd carries forward speed, turn rate and elapsed
// time. Each command yields exactly one pose transfer on o_pose: x and y in
// 1/65536 m (saturating), a 16-bit binary heading and the yaw quaternion
// z and w in Q1.15. A command of zero speed and zero rate reports the pose
// unchanged.
// A command runs in phases: first the CORDIC turns the old heading while the
// multipliers form |v|*dt and |w|*dt; then the multipliers scale |v|*dt by
// |cos| and |sin| while the heading divider runs; last the position dividers
// run as the CORDIC forms the new heading's quaternion. i_cmd.ready rises in
// the same cycle as o_pose.valid, so no command is taken while one is in work.
// The phases use bit-serial multipliers, bit-serial dividers (18 quotient bits
// for position, HEADING_WIDTH for the heading) and the one-rotation-per-cycle
// CORDIC, shared by the sine/cosine of the old heading and the new quaternion.
// The finished pose sits in an output register, so a new command is taken
// while o_pose is stalled; that command is processed and then waits for the
// register to drain before its result is written.
// Synchronous reset clears the pose to zero and drops o_pose.valid.
// ----------------------------------------------------------------------------
module dead_reckoning_odometry_top #(
    parameter int CORDIC_STEPS   = 16,
    parameter int POSITION_WIDTH = 32,
    parameter int HEADING_WIDTH  = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    dro_stream_if.sink          i_cmd,
    dro_stream_if.source        o_pose
);
    import dro_pkg::*;

    localparam int PW   = POSITION_WIDTH;
    localparam int HW   = HEADING_WIDTH;
    // Heading dividend: |w|*dt (31 bits) shifted by HW, plus half the divisor.
    localparam int DH_W = MUL_A_W + 1 + HW;

    // Sequencer and architectural state.
    t_state               r_state, n_state;
    logic [HW-1:0]        r_heading, n_heading;
    logic signed [PW-1:0] r_pos_x, r_pos_y, n_pos_x, n_pos_y;
    logic                 r_neg_v, r_neg_w, r_neg_x, r_neg_y;
    logic                 r_out_valid;
    t_pose_item           r_out;

    // Phase control.
    logic cmd_take, start_scale, start_divide, pos_update, emit_go;
    logic trig_idle, scale_idle, divide_idle;

    // Unit connections.
    logic                   cordic_start, cordic_busy;
    logic [ANGLE_W-1:0]     cordic_angle;
    logic signed [15:0]     cordic_cos, cordic_sin;
    logic                   mulx_start, mulx_busy, muly_busy;
    logic [MUL_A_W-1:0]     mulx_a, muly_a;
    logic [MUL_B_W-1:0]     mulx_b, muly_b;
    logic [MUL_P_W-1:0]     mulx_product, muly_product;
    logic                   divh_busy, divx_busy, divy_busy;
    logic [DH_W-1:0]        divh_dividend;
    logic [HW-1:0]          divh_quot;
    logic [MUL_P_W-1:0]     divx_dividend, divy_dividend;
    logic [POS_QUOT_W-1:0]  divx_quot, divy_quot;

    logic [15:0]            v_mag, w_mag, cos_mag, sin_mag;
    logic signed [POS_QUOT_W:0] delta_x, delta_y;
    logic signed [PW:0]     sum_x, sum_y;
    logic [HW+15:0]         heading_ext;

    function automatic logic signed [PW-1:0] sat_pos(input logic signed [PW:0] s);
        logic signed [PW-1:0] res;
        if (s[PW] != s[PW-1]) begin
            res = s[PW] ? {1'b1, {(PW-1){1'b0}}} : {1'b0, {(PW-1){1'b1}}};
        end else begin
            res = s[PW-1:0];
        end
        return res;
    endfunction

    assign trig_idle   = !cordic_busy && !mulx_busy && !muly_busy;
    assign scale_idle  = !mulx_busy && !muly_busy && !divh_busy;
    assign divide_idle = !divx_busy && !divy_busy && !cordic_busy;

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_cmd.valid) begin
                    n_state = ST_TRIG;
                end
            end
            ST_TRIG: begin
                if (trig_idle) begin
                    n_state = ST_SCALE;
                end
            end
            ST_SCALE: begin
                if (scale_idle) begin
                    n_state = ST_DIVIDE;
                end
            end
            ST_DIVIDE: begin
                if (divide_idle) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (!r_out_valid || o_pose.ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Phase strobes.
    always_comb begin
        cmd_take     = 1'b0;
        start_scale  = 1'b0;
        start_divide = 1'b0;
        pos_update   = 1'b0;
        emit_go      = 1'b0;
        unique case (r_state)
            ST_IDLE:   cmd_take     = i_cmd.valid;
            ST_TRIG:   start_scale  = trig_idle;
            ST_SCALE:  start_divide = scale_idle;
            ST_DIVIDE: pos_update   = divide_idle;
            ST_EMIT:   emit_go      = !r_out_valid || o_pose.ready;
            default:   cmd_take     = 1'b0;
        endcase
    end

    // Magnitudes; the signs travel separately so the serial units stay
    // unsigned. Negating the most negative value gives 0x8000, read unsigned.
    always_comb begin
        v_mag   = i_cmd.data.linear_velocity[15]
                ? (~i_cmd.data.linear_velocity + 16'd1) : i_cmd.data.linear_velocity;
        w_mag   = i_cmd.data.angular_velocity[15]
                ? (~i_cmd.data.angular_velocity + 16'd1) : i_cmd.data.angular_velocity;
        cos_mag = cordic_cos[15] ? (~cordic_cos + 16'd1) : cordic_cos;
        sin_mag = cordic_sin[15] ? (~cordic_sin + 16'd1) : cordic_sin;
    end

    // Operand routing. In the first phase the multipliers form |v|*dt and
    // |w|*dt; in the second they scale |v|*dt by |cos| and |sin|.
    always_comb begin
        mulx_start   = cmd_take || start_scale;
        mulx_a       = cmd_take ? MUL_A_W'(v_mag) : mulx_product[MUL_A_W-1:0];
        mulx_b       = cmd_take ? i_cmd.data.elapsed_time : cos_mag;
        muly_a       = cmd_take ? MUL_A_W'(w_mag) : mulx_product[MUL_A_W-1:0];
        muly_b       = cmd_take ? i_cmd.data.elapsed_time : sin_mag;

        n_heading    = r_neg_w ? (r_heading - divh_quot) : (r_heading + divh_quot);

        // The old heading drives the first rotation, the half of the new
        // heading drives the quaternion rotation.
        cordic_start = cmd_take || start_divide;
        cordic_angle = cmd_take ? {r_heading, {(ANGLE_W-HW){1'b0}}}
                                : {1'b0, n_heading, {(ANGLE_W-1-HW){1'b0}}};

        divh_dividend = (DH_W'(muly_product[MUL_A_W-1:0]) << HW) + DH_W'(TURN_HALF);
        divx_dividend = mulx_product + MUL_P_W'(POS_HALF);
        divy_dividend = muly_product + MUL_P_W'(POS_HALF);

        delta_x = r_neg_x ? -signed'({1'b0, divx_quot}) : signed'({1'b0, divx_quot});
        delta_y = r_neg_y ? -signed'({1'b0, divy_quot}) : signed'({1'b0, divy_quot});
        sum_x   = (PW+1)'(r_pos_x) + (PW+1)'(delta_x);
        sum_y   = (PW+1)'(r_pos_y) + (PW+1)'(delta_y);
        n_pos_x = sat_pos(sum_x);
        n_pos_y = sat_pos(sum_y);
    end

    // The reported heading is the top 16 bits of the heading padded below.
    assign heading_ext = {r_heading, 16'b0};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_heading   <= '0;
            r_pos_x     <= '0;
            r_pos_y     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (start_divide) begin
                r_heading <= n_heading;
            end
            if (pos_update) begin
                r_pos_x <= n_pos_x;
                r_pos_y <= n_pos_y;
            end
            if (emit_go) begin
                r_out_valid <= 1'b1;
            end else if (o_pose.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Sign bits and the output register hold payload only.
    always_ff @(posedge i_clk) begin
        if (cmd_take) begin
            r_neg_v <= i_cmd.data.linear_velocity[15];
            r_neg_w <= i_cmd.data.angular_velocity[15];
        end
        if (start_scale) begin
            r_neg_x <= r_neg_v ^ cordic_cos[15];
            r_neg_y <= r_neg_v ^ cordic_sin[15];
        end
        if (emit_go) begin
            r_out.position_x <= 32'(r_pos_x);
            r_out.position_y <= 32'(r_pos_y);
            r_out.heading    <= heading_ext[HW+15 -: 16];
            r_out.quat_z     <= cordic_sin;
            r_out.quat_w     <= cordic_cos;
        end
    end

    assign i_cmd.ready  = (r_state == ST_IDLE);
    assign o_pose.valid = r_out_valid;
    assign o_pose.data  = r_out;

    dro_cordic #(
        .STEPS (CORDIC_STEPS)
    ) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (cordic_start),
        .i_angle (cordic_angle),
        .o_busy  (cordic_busy),
        .o_cos   (cordic_cos),
        .o_sin   (cordic_sin)
    );

    dro_serial_mul #(
        .A_W (MUL_A_W),
        .B_W (MUL_B_W)
    ) u_mul_x (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (mulx_start),
        .i_a       (mulx_a),
        .i_b       (mulx_b),
        .o_busy    (mulx_busy),
        .o_product (mulx_product)
    );

    dro_serial_mul #(
        .A_W (MUL_A_W),
        .B_W (MUL_B_W)
    ) u_mul_y (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (mulx_start),
        .i_a       (muly_a),
        .i_b       (muly_b),
        .o_busy    (muly_busy),
        .o_product (muly_product)
    );

    dro_serial_div #(
        .DIVIDEND_W (DH_W),
        .QUOT_W     (HW),
        .DIVISOR_W  (TURN_DIV_W),
        .DIVISOR    (TURN_DIVISOR)
    ) u_div_heading (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (start_scale),
        .i_dividend (divh_dividend),
        .o_busy     (divh_busy),
        .o_quotient (divh_quot)
    );

    dro_serial_div #(
        .DIVIDEND_W (MUL_P_W),
        .QUOT_W     (POS_QUOT_W),
        .DIVISOR_W  (POS_DIV_W),
        .DIVISOR    (POS_DIVISOR)
    ) u_div_x (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (start_divide),
        .i_dividend (divx_dividend),
        .o_busy     (divx_busy),
        .o_quotient (divx_quot)
    );

    dro_serial_div #(
        .DIVIDEND_W (MUL_P_W),
        .QUOT_W     (POS_QUOT_W),
        .DIVISOR_W  (POS_DIV_W),
        .DIVISOR    (POS_DIVISOR)
    ) u_div_y (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (start_divide),
        .i_dividend (divy_dividend),
        .o_busy     (divy_busy),
        .o_quotient (divy_quot)
    );

endmodule

FILE: hdl/dro_cordic.sv
// ----------------------------------------------------------------------------
// Iterative CORDIC
// Rotation-mode CORDIC, one micro-rotation per cycle, giving cos and sin of a
// full-turn angle in Q1.15.
// ----------------------------------------------------------------------------
module dro_cordic #(
    parameter int STEPS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [dro_pkg::ANGLE_W-1:0]   i_angle,
    output logic                          o_busy,
    output logic signed [15:0]            o_cos,
    output logic signed [15:0]            o_sin
);
    import dro_pkg::*;

    localparam int ITER_W = $clog2(STEPS);
    localparam logic signed [XY_W-16:0] Q15_MAX = (XY_W-15)'(32767);
    localparam logic signed [XY_W-16:0] Q15_MIN = (XY_W-15)'(-32768);

    logic                   r_busy;
    logic [ITER_W-1:0]      r_iter;
    logic                   r_flip;
    logic signed [XY_W-1:0] r_x, r_y, r_z;

    logic signed [XY_W-1:0] dx, dy, atan_step;
    logic                   flip_in;
    logic [ANGLE_W-1:0]     folded;

    // Round to Q1.15 with the half added before a floor shift, then clamp.
    function automatic logic signed [15:0] to_q15(input logic signed [XY_W-1:0] v);
        logic signed [XY_W-1:0]  rounded;
        logic signed [XY_W-16:0] shifted;
        rounded = v + XY_W'(16384);
        shifted = (XY_W-15)'(rounded >>> 15);
        if (shifted > Q15_MAX) begin
            shifted = Q15_MAX;
        end else if (shifted < Q15_MIN) begin
            shifted = Q15_MIN;
        end
        return shifted[15:0];
    endfunction

    // Angles in the second and third quadrants are turned by half a turn and
    // the result negated afterwards.
    assign flip_in   = i_angle[ANGLE_W-1] ^ i_angle[ANGLE_W-2];
    assign folded    = {i_angle[ANGLE_W-1] ^ flip_in, i_angle[ANGLE_W-2:0]};
    assign dx        = r_y >>> r_iter;
    assign dy        = r_x >>> r_iter;
    assign atan_step = XY_W'(atan_turn(5'(r_iter)));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_iter <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_iter <= '0;
        end else if (r_busy) begin
            r_iter <= r_iter + 1'b1;
            if (r_iter == ITER_W'(STEPS-1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_flip <= flip_in;
            r_x    <= CORDIC_GAIN;
            r_y    <= '0;
            r_z    <= XY_W'(signed'(folded));
        end else if (r_busy) begin
            if (!r_z[XY_W-1]) begin
                r_x <= r_x - dx;
                r_y <= r_y + dy;
                r_z <= r_z - atan_step;
            end else begin
                r_x <= r_x + dx;
                r_y <= r_y - dy;
                r_z <= r_z + atan_step;
            end
        end
    end

    assign o_busy = r_busy;
    assign o_cos  = to_q15(r_flip ? -r_x : r_x);
    assign o_sin  = to_q15(r_flip ? -r_y : r_y);

endmodule

FILE: hdl/dro_serial_mul.sv
// ----------------------------------------------------------------------------
// Serial multiplier
// Unsigned shift-add multiplier taking one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module dro_serial_mul #(
    parameter int A_W = 31,
    parameter int B_W = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [A_W-1:0]     i_a,
    input  logic [B_W-1:0]     i_b,
    output logic               o_busy,
    output logic [A_W+B_W-1:0] o_product
);
    localparam int CNT_W = $clog2(B_W);

    logic                 r_busy;
    logic [CNT_W-1:0]     r_cnt;
    logic [A_W-1:0]       r_a;
    // Upper part accumulates partial products, lower part shifts the
    // multiplier bits out and the product bits in.
    logic [A_W+B_W:0]     r_p;

    logic [A_W:0]         hi_sum;
    logic [A_W+B_W:0]     n_p;

    always_comb begin
        hi_sum = r_p[A_W+B_W:B_W] + (r_p[0] ? {1'b0, r_a} : '0);
        n_p    = {1'b0, hi_sum, r_p[B_W-1:1]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == CNT_W'(B_W-1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a <= i_a;
            r_p <= {{(A_W+1){1'b0}}, i_b};
        end else if (r_busy) begin
            r_p <= n_p;
        end
    end

    assign o_busy    = r_busy;
    assign o_product = r_p[A_W+B_W-1:0];

endmodule

FILE: hdl/dro_serial_div.sv
// ----------------------------------------------------------------------------
// Serial divider
// Restoring division by a fixed divisor, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module dro_serial_div #(
    parameter int                   DIVIDEND_W = 47,
    parameter int                   QUOT_W     = 18,
    parameter int                   DIVISOR_W  = 29,
    parameter logic [DIVISOR_W-1:0] DIVISOR    = {DIVISOR_W{1'b1}}
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [DIVIDEND_W-1:0] i_dividend,
    output logic                  o_busy,
    output logic [QUOT_W-1:0]     o_quotient
);
    localparam int CNT_W = $clog2(QUOT_W);

    logic                  r_busy;
    logic [CNT_W-1:0]      r_cnt;
    logic [DIVISOR_W-1:0]  r_rem;
    // Low dividend bits leave at the top while quotient bits enter below.
    logic [QUOT_W-1:0]     r_quot;

    logic [DIVISOR_W:0]    trial, diff;
    logic                  fits;
    logic [DIVISOR_W-1:0]  n_rem;

    always_comb begin
        trial = {r_rem, r_quot[QUOT_W-1]};
        diff  = trial - {1'b0, DIVISOR};
        fits  = (trial >= {1'b0, DIVISOR});
        n_rem = fits ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == CNT_W'(QUOT_W-1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    // The high dividend part is always below the divisor, so it seeds the
    // partial remainder directly.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= DIVISOR_W'(i_dividend >> QUOT_W);
            r_quot <= i_dividend[QUOT_W-1:0];
        end else if (r_busy) begin
            r_rem  <= n_rem;
            r_quot <= {r_quot[QUOT_W-2:0], fits};
        end
    end

    assign o_busy     = r_busy;
    assign o_quotient = r_quot;

endmodule

FILE: test/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Dead-reckoning odometry testbench
// Drives speed/turn/time commands into the odometry block, predicts every
// pose with a bit-accurate model of the integrator and its CORDIC, and checks
// each pose transfer in order while both channels idle and stall at random.
// ----------------------------------------------------------------------------
module tb;

    import dro_pkg::*;

    localparam int CLK_HALF_NS    = 4;
    localparam int RESET_CYCLES   = 4;
    localparam int RANDOM_ITEMS   = 1400;
    // A short full-speed run along +x at heading zero.
    localparam int STRAIGHT_TICKS = 100;
    localparam int QUIET_LIMIT    = 4000;
    localparam int END_TAIL       = 100;
    localparam int MAX_REPORTS    = 10;

    // Fixed-point scale factors of the pose update.
    localparam longint unsigned POS_SCALE_DEN  = 64'd512000000;
    localparam longint unsigned TURN_SCALE_DEN = 64'd25735927018;
    localparam longint          ROT_GAIN       = 64'sd652032874;
    localparam int              ROT_STEPS      = 16;

    typedef struct {
        t_cmd_item   cmd;
        bit          drain;      // hold off until every pose has arrived
        int unsigned gap_pct;    // sender idle odds while this item is current
        int unsigned stall_pct;  // receiver stall odds while this item is current
    } t_cmd_slot;

    logic clk;
    logic rst_n;

    dro_stream_if #(.T(t_cmd_item))  cmd_if ();
    dro_stream_if #(.T(t_pose_item)) pose_if ();

    dead_reckoning_odometry_top u_top (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_cmd   (cmd_if),
        .o_pose  (pose_if)
    );

    // atan(2^-i) as a fraction of a full turn, scaled by 2^32.
    longint atan_turn_tab [ROT_STEPS] = '{
        64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4,
        64'h028B0D43, 64'h0145D7E1, 64'h00A2F61E, 64'h00517C55,
        64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
        64'h00028BE6, 64'h000145F3, 64'h0000A2F9, 64'h0000517D
    };

    // Pose predictor state, advanced once per accepted command.
    longint      pose_x;
    longint      pose_y;
    logic [15:0] pose_heading;

    // Heading as the stimulus planner sees it after all queued commands.
    logic [15:0] plan_heading;

    t_cmd_slot   cmd_pending [$];
    t_pose_item  pose_expected [$];

    int          cmds_total;
    int          cmds_accepted;
    int          mismatches;
    int unsigned cur_gap_pct;
    int unsigned cur_stall_pct;
    int          gap_left;
    bit          gap_hold;
    int          stall_left;
    int          quiet_cycles;

    always begin
        #(CLK_HALF_NS) clk = 1'b1;
        #(CLK_HALF_NS) clk = 1'b0;
    end

    // round(a * mul / den) with ties away from zero.
    function automatic longint round_scaled(input longint a, input longint unsigned mul,
                                            input longint unsigned den);
        longint unsigned mag;
        longint unsigned quo;
        mag = (a < 0) ? -a : a;
        mag = mag * mul;
        quo = (mag + den / 2) / den;
        return (a < 0) ? -longint'(quo) : longint'(quo);
    endfunction

    function automatic longint turn_step(input longint rate, input longint dt);
        return round_scaled(rate * dt, 64'd65536, TURN_SCALE_DEN);
    endfunction

    function automatic int to_q15(input longint v);
        longint r;
        r = (v + 64'sd16384) >>> 15;
        if (r > 32767) r = 32767;
        if (r < -32768) r = -32768;
        return int'(r);
    endfunction

    // Cosine and sine of a 32-bit full-turn angle. The second and third quadrants are
    // folded by half a turn so the rotation only covers +-90 degrees.
    function automatic void trig_q15(input logic [31:0] ang, output int c, output int s);
        logic [31:0] a;
        bit          flip;
        longint      x;
        longint      y;
        longint      z;
        longint      dx;
        longint      dy;
        a    = ang;
        flip = (a[31:30] == 2'b01) || (a[31:30] == 2'b10);
        if (flip) a = a - 32'h8000_0000;
        z = longint'(signed'(a));
        x = ROT_GAIN;
        y = 0;
        for (int i = 0; i < ROT_STEPS; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x = x - dx;
                y = y + dy;
                z = z - atan_turn_tab[i];
            end else begin
                x = x + dx;
                y = y - dy;
                z = z + atan_turn_tab[i];
            end
        end
        if (flip) begin
            x = -x;
            y = -y;
        end
        c = to_q15(x);
        s = to_q15(y);
    endfunction

    function automatic longint clamp_pos(input longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    // Moves along the old heading first, then turns, then reports the pose.
    function automatic t_pose_item advance_pose(input t_cmd_item cmd);
        longint     v;
        longint     w;
        longint     dt;
        longint     dh;
        int         c;
        int         s;
        int         qz;
        int         qw;
        t_pose_item p;
        v  = longint'(signed'(cmd.linear_velocity));
        w  = longint'(signed'(cmd.angular_velocity));
        dt = longint'(cmd.elapsed_time);
        trig_q15({pose_heading, 16'h0000}, c, s);
        pose_x = clamp_pos(pose_x + round_scaled(v * c, dt, POS_SCALE_DEN));
        pose_y = clamp_pos(pose_y + round_scaled(v * s, dt, POS_SCALE_DEN));
        dh = turn_step(w, dt);
        pose_heading = pose_heading + dh[15:0];
        trig_q15({1'b0, pose_heading, 15'h0000}, qw, qz);
        p.position_x = pose_x[31:0];
        p.position_y = pose_y[31:0];
        p.heading    = pose_heading;
        p.quat_z     = qz[15:0];
        p.quat_w     = qw[15:0];
        return p;
    endfunction

    function automatic void check_pose(input t_pose_item got);
        t_pose_item want;
        if (pose_expected.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("ERROR @%0t: pose with nothing expected: x=%0d y=%0d h=%0d z=%0d w=%0d",
                         $time, got.position_x, got.position_y, got.heading,
                         got.quat_z, got.quat_w);
            return;
        end
        want = pose_expected.pop_front();
        if (got.position_x !== want.position_x || got.position_y !== want.position_y ||
            got.heading !== want.heading || got.quat_z !== want.quat_z ||
            got.quat_w !== want.quat_w) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS) begin
                $display("ERROR @%0t: pose mismatch", $time);
                $display("  expected x=%0d y=%0d h=%0d z=%0d w=%0d", want.position_x,
                         want.position_y, want.heading, want.quat_z, want.quat_w);
                $display("  actual   x=%0d y=%0d h=%0d z=%0d w=%0d", got.position_x,
                         got.position_y, got.heading, got.quat_z, got.quat_w);
            end
        end
    endfunction

    task automatic queue_cmd(input int v, input int w, input int dt, input bit drain,
                             input int unsigned gap, input int unsigned stall);
        t_cmd_slot  slot;
        longint     dh;
        slot.cmd.linear_velocity  = 16'(v);
        slot.cmd.angular_velocity = 16'(w);
        slot.cmd.elapsed_time     = 16'(dt);
        slot.drain     = drain;
        slot.gap_pct   = gap;
        slot.stall_pct = stall;
        cmd_pending.push_back(slot);
        cmds_total++;
        dh = turn_step(longint'(signed'(slot.cmd.angular_velocity)),
                       longint'(slot.cmd.elapsed_time));
        plan_heading = plan_heading + dh[15:0];
    endtask

    // Turns on the spot, at most about 5000 steps per tick, until the planned
    // heading lands exactly on the target.
    task automatic steer_heading(input logic [15:0] target);
        int  remaining;
        int  step;
        int  rate;
        bit  found;
        while (plan_heading != target) begin
            remaining = int'(signed'(16'(target - plan_heading)));
            step = (remaining > 5000) ? 5000 : ((remaining < -5000) ? -5000 : remaining);
            rate  = step * 5992 / 1000;
            found = 1'b0;
            for (int r = step * 5992 / 1000 - 8; r <= step * 5992 / 1000 + 8; r++) begin
                if (!found && turn_step(r, 65535) == step) begin
                    rate  = r;
                    found = 1'b1;
                end
            end
            queue_cmd(0, rate, 65535, 1'b0, 0, 0);
        end
    endtask

    // Sender: presents the next pending command, holds it until the transfer,
    // and inserts random idle bursts between commands.
    always @(posedge clk) begin
        t_cmd_slot slot;
        if (!rst_n) begin
            cmd_if.valid <= 1'b0;
            gap_left = 0;
            gap_hold = 1'b0;
        end else begin
            if (cmd_if.valid && cmd_if.ready) begin
                pose_expected.push_back(advance_pose(cmd_if.data));
                cmds_accepted++;
            end
            if (cmd_if.valid && !cmd_if.ready) begin
                // Command still waiting for its transfer: keep it on the bus.
            end else if (gap_hold) begin
                // Line the burst up with the block's return to ready.
                cmd_if.valid <= 1'b0;
                if (cmd_if.ready) gap_hold = 1'b0;
            end else if (gap_left != 0) begin
                cmd_if.valid <= 1'b0;
                gap_left--;
            end else if (cmd_pending.size() == 0 ||
                         (cmd_pending[0].drain && pose_expected.size() != 0)) begin
                cmd_if.valid <= 1'b0;
            end else if (cur_gap_pct != 0 && $urandom_range(0, 99) < cur_gap_pct) begin
                cmd_if.valid <= 1'b0;
                gap_left = $urandom_range(0, 15);
                gap_hold = ($urandom_range(0, 2) == 0);
            end else begin
                slot = cmd_pending.pop_front();
                cmd_if.valid  <= 1'b1;
                cmd_if.data   <= slot.cmd;
                cur_gap_pct   = slot.gap_pct;
                cur_stall_pct = slot.stall_pct;
            end
        end
    end

    // Receiver: checks each pose transfer and stalls in random bursts.
    always @(posedge clk) begin
        if (!rst_n) begin
            pose_if.ready <= 1'b0;
            stall_left = 0;
        end else begin
            if (pose_if.valid && pose_if.ready) check_pose(pose_if.data);
            if (stall_left != 0) begin
                pose_if.ready <= 1'b0;
                stall_left--;
            end else if (cur_stall_pct != 0 && $urandom_range(0, 99) < cur_stall_pct) begin
                pose_if.ready <= 1'b0;
                stall_left = $urandom_range(0, 15);
            end else begin
                pose_if.ready <= 1'b1;
            end
        end
    end

    // Ends the run when neither channel has moved for too long.
    always @(posedge clk) begin
        if (!rst_n || (cmd_if.valid && cmd_if.ready) || (pose_if.valid && pose_if.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Verification failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        int          corner_vals [5] = '{-32768, 32767, 0, -1, 1};
        int          dt_corners [3]  = '{0, 1, 65535};
        int unsigned pct_choices [4] = '{0, 5, 20, 50};
        int unsigned gap;
        int unsigned stall;
        int          v;
        int          w;
        int          dt;

        clk           = 1'b0;
        rst_n         = 1'b0;
        cmd_if.valid  = 1'b0;
        cmd_if.data   = '0;
        pose_if.ready = 1'b0;
        pose_x        = 0;
        pose_y        = 0;
        pose_heading  = '0;
        plan_heading  = '0;
        cmds_total    = 0;
        cmds_accepted = 0;
        mismatches    = 0;
        cur_gap_pct   = 20;
        cur_stall_pct = 20;
        quiet_cycles  = 0;

        // Directed part. The first moves run at heading zero, where the cosine
        // of exactly one saturates to the largest Q1.15 value.
        queue_cmd(0, 0, 0, 1'b0, 20, 20);              // no message, nothing elapsed
        queue_cmd(32767, 0, 65535, 1'b0, 20, 20);      // fastest forward step
        queue_cmd(-32768, 0, 65535, 1'b0, 20, 20);     // fastest reverse step
        queue_cmd(0, 0, 65535, 1'b0, 20, 20);          // no message, pose must hold
        queue_cmd(0, -32768, 65535, 1'b0, 20, 20);     // heading wraps below zero
        queue_cmd(0, 32767, 65535, 1'b0, 20, 20);
        queue_cmd(32767, 32767, 65535, 1'b0, 20, 20);
        queue_cmd(-32768, -32768, 65535, 1'b0, 20, 20);
        queue_cmd(32767, -32768, 1, 1'b0, 20, 20);
        queue_cmd(-1, 1, 1, 1'b0, 20, 20);
        queue_cmd(1, -1, 65535, 1'b0, 20, 20);
        queue_cmd(12345, -23456, 0, 1'b0, 20, 20);     // command with no elapsed time
        queue_cmd(-32768, 32767, 32768, 1'b0, 20, 20);
        // Sweep through all four quadrants and past a full turn.
        for (int k = 0; k < 12; k++)
            queue_cmd(20000, 32767, 65535, 1'b0, 20, 20);

        // Drive straight along +x at full speed for a while. The sender first
        // waits for every outstanding pose before the turn-in starts.
        queue_cmd(0, 0, 1000, 1'b1, 0, 0);
        steer_heading(16'h0000);
        for (int k = 0; k < STRAIGHT_TICKS; k++)
            queue_cmd(32767, 0, 65535, 1'b0, 0, 0);

        // Random part: idle and stall odds change every hundred commands, and
        // the closing stretch runs with neither.
        gap   = 0;
        stall = 0;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 100 == 0) begin
                gap   = pct_choices[$urandom_range(0, 3)];
                stall = pct_choices[$urandom_range(0, 3)];
            end
            if (n >= RANDOM_ITEMS - 200) begin
                gap   = 0;
                stall = 0;
            end
            case ($urandom_range(0, 9))
                0: begin
                    v  = 0;
                    w  = 0;
                    dt = $urandom_range(0, 65535);
                end
                1: begin
                    v  = corner_vals[$urandom_range(0, 4)];
                    w  = corner_vals[$urandom_range(0, 4)];
                    dt = dt_corners[$urandom_range(0, 2)];
                end
                default: begin
                    v  = int'($urandom_range(0, 65535)) - 32768;
                    w  = int'($urandom_range(0, 65535)) - 32768;
                    dt = $urandom_range(0, 65535);
                end
            endcase
            queue_cmd(v, w, dt, (n % 300 == 150), gap, stall);
        end

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        while (cmds_accepted != cmds_total) @(posedge clk);
        while (pose_expected.size() != 0) @(posedge clk);
        repeat (END_TAIL) @(posedge clk);

        if (mismatches == 0 && pose_expected.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
